// ===== hw/rtl/mtp_pkg.sv =====
// ----------------------------------------------------------------------------
// mtp_pkg
// Shared types and constants of the multichannel tick pwm block.
// ----------------------------------------------------------------------------
`default_nettype none

package mtp_pkg;

  // fixed field widths
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned CHAN_W = 2;
  localparam int unsigned PIN_W  = 3;

  // wide enough for any supported channel index
  localparam int unsigned IDX_W  = 8;

  // parameter defaults
  localparam int unsigned NUM_CHANNELS_DEF = 3;
  localparam int unsigned PERIOD_TICKS_DEF = 256;

  // input word kinds
  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_WRITE = 1'b1
  } action_e;

  // per-channel control for one accepted word
  typedef struct packed {
    logic tick;   // accepted tick word
    logic start;  // this tick begins a new period
    logic wr;     // duty write aimed at this channel
  } mtp_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mtp_channel.sv =====
// ----------------------------------------------------------------------------
// mtp_channel
// One pwm channel: stored duty, high-time countdown and output level.
// ----------------------------------------------------------------------------
`default_nettype none

module mtp_channel
  import mtp_pkg::*;
#(
  parameter int unsigned PeriodTicks = PERIOD_TICKS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mtp_ctrl_t        ctrl_i,
  input  wire logic [CNT_W-1:0] duty_i,
  output logic                  level_d_o
);

  localparam logic [CNT_W-1:0] Period = CNT_W'(PeriodTicks);

  logic [CNT_W-1:0] duty_q, duty_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             level_q, level_d;
  logic             running;

  // channel counts only while high and below the period
  assign running = level_q && (cnt_q < Period);

  // next state of store, countdown and level
  always_comb begin
    duty_d  = duty_q;
    cnt_d   = cnt_q;
    level_d = level_q;
    if (ctrl_i.wr) begin
      duty_d = duty_i;
    end
    if (ctrl_i.tick) begin
      if (ctrl_i.start) begin
        cnt_d   = duty_q;
        level_d = (duty_q != '0);
      end else if (running) begin
        cnt_d   = cnt_q - 1'b1;
        level_d = (cnt_q != CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q  <= '0;
      cnt_q   <= '0;
      level_q <= 1'b0;
    end else begin
      duty_q  <= duty_d;
      cnt_q   <= cnt_d;
      level_q <= level_d;
    end
  end

  assign level_d_o = level_d;

endmodule

`default_nettype wire

// ===== hw/rtl/multichannel_tick_pwm.sv =====
// ----------------------------------------------------------------------------
// multichannel_tick_pwm
// Tick-driven pwm generator with a per-channel duty store.
// ----------------------------------------------------------------------------
// One word is taken every cycle: a tick advances the period counter and all
// channels in parallel, a write stores one channel's duty for the next
// period. Each word gives one result word in the cycle after it is taken,
// held in an output register; the input stalls only while that register
// is full and its reader stalls. Levels of channels 0 to 2 are shown.
`default_nettype none

module multichannel_tick_pwm
  import mtp_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int unsigned PERIOD_TICKS = PERIOD_TICKS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input words
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              action_i,
  input  wire logic [CHAN_W-1:0] channel_i,
  input  wire logic [CNT_W-1:0]  duty_value_i,
  // result words
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [PIN_W-1:0]       pin_levels_o,
  output logic                   period_start_o
);

  localparam logic [CNT_W-1:0] Period = CNT_W'(PERIOD_TICKS);

  logic                    in_accept;
  logic                    is_tick;
  logic                    is_write;
  logic                    start;
  logic [IDX_W-1:0]        chan_idx;
  logic [CNT_W-1:0]        period_q, period_d;
  logic [NUM_CHANNELS-1:0] levels_d;
  logic [PIN_W-1:0]        pins_d;
  mtp_ctrl_t               ctrl [NUM_CHANNELS];

  logic                    out_valid_q, out_valid_d;
  logic [PIN_W-1:0]        pins_q;
  logic                    start_q;

  // handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_tick    = in_accept && (action_e'(action_i) == ACT_TICK);
  assign is_write   = in_accept && (action_e'(action_i) == ACT_WRITE);
  assign chan_idx   = IDX_W'(channel_i);

  // period counter, reloads when it would reach zero
  assign start = is_tick && (period_q == CNT_W'(1));

  always_comb begin
    period_d = period_q;
    if (is_tick) begin
      period_d = start ? Period : (period_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= CNT_W'(1);
    end else begin
      period_q <= period_d;
    end
  end

  // channels
  for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_chan
    assign ctrl[ch].tick  = is_tick;
    assign ctrl[ch].start = start;
    assign ctrl[ch].wr    = is_write && (chan_idx == IDX_W'(ch));

    mtp_channel #(
      .PeriodTicks(PERIOD_TICKS)
    ) u_chan (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl[ch]),
      .duty_i   (duty_value_i),
      .level_d_o(levels_d[ch])
    );
  end

  // visible pins, absent channels read low
  for (genvar b = 0; b < PIN_W; b++) begin : g_pin
    if (b < NUM_CHANNELS) begin : g_on
      assign pins_d[b] = levels_d[b];
    end else begin : g_off
      assign pins_d[b] = 1'b0;
    end
  end

  // output register
  assign out_valid_d = in_accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pins_q  <= pins_d;
      start_q <= start;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pin_levels_o   = pins_q;
  assign period_start_o = start_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mtp_checker.sv =====
// ----------------------------------------------------------------------------
// mtp_checker
// Port-level checks of the multichannel tick pwm block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mtp_checker
  import mtp_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              action_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [PIN_W-1:0]  pin_levels_o,
  input wire logic              period_start_o
);

  // input stalls only behind a full, stalled output register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting result");

  // every accepted word gives a result next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted word gave no result");

  // a write never starts a period
  a_write_no_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (action_e'(action_i) == ACT_WRITE))
      |=> !period_start_o)
    else $error("write word flagged a period start");

  // a stalled result holds its levels
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(pin_levels_o)))
    else $error("stalled result changed");

endmodule

bind multichannel_tick_pwm mtp_checker u_mtp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .action_i      (action_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pin_levels_o  (pin_levels_o),
  .period_start_o(period_start_o)
);

`default_nettype wire
